// ----- hw/rtl/rau_pkg.sv -----
// Package for the rational arithmetic unit: action and status codes, sequencer states.
`default_nettype none
package rau_pkg;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_COMB,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_FIN
  } state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/rau_if.sv -----
// Request and response channel interfaces of the rational arithmetic unit.
`default_nettype none
interface rau_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic signed [31:0] a_num;
  logic [30:0] a_den;
  logic signed [31:0] b_num;
  logic [30:0] b_den;

  modport source (output valid, action, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, action, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_rsp_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] res_num;
  logic [30:0] res_den;
  logic [1:0]  status;

  modport source (output valid, res_num, res_den, status, input ready);
  modport sink (input valid, res_num, res_den, status, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/rau_mul.sv -----
// Registered 33x33 signed multiplier shared by all cross products.
`default_nettype none
module rau_mul (
  input  wire logic               clk,
  input  wire logic signed [32:0] op_a,
  input  wire logic signed [32:0] op_b,
  output logic signed [63:0]      prod
);
  logic signed [65:0] full;

  assign full = op_a * op_b;

  always_ff @(posedge clk) begin
    prod <= full[63:0];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/rau_gcd.sv -----
// Binary gcd unit: one shift or subtract per cycle on 64-bit magnitudes.
`default_nettype none
module rau_gcd (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      g
);
  logic        busy;
  logic [63:0] u;
  logic [63:0] v;
  logic [5:0]  k;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && u == 64'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      u <= a;
      v <= b;
      k <= 6'd0;
    end else if (busy) begin
      if (u == 64'd0) begin
        g <= v << k;
      end else if (!u[0] && !v[0]) begin
        u <= u >> 1;
        v <= v >> 1;
        k <= k + 6'd1;
      end else if (!u[0]) begin
        u <= u >> 1;
      end else if (!v[0]) begin
        v <= v >> 1;
      end else if (u >= v) begin
        u <= u - v;
      end else begin
        v <= v - u;
      end
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/rau_div.sv -----
// Restoring divider producing a 64-bit quotient, one quotient bit per cycle.
`default_nettype none
module rau_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [63:0] divisor,
  output logic             done,
  output logic [63:0]      quotient
);
  logic        busy;
  logic [5:0]  cnt;
  logic [63:0] rem;
  logic [63:0] dvs;
  logic [63:0] sh;

  // remainder stays below divisor < 2^63, so the shift never drops a bit
  assign sh = {rem[62:0], quotient[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= 64'd0;
      quotient <= dividend;
      dvs      <= divisor;
    end else if (busy) begin
      if (sh >= dvs) begin
        rem      <= sh - dvs;
        quotient <= {quotient[62:0], 1'b1};
      end else begin
        rem      <= sh;
        quotient <= {quotient[62:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/rational_arithmetic_unit.sv -----
// Top level of the rational arithmetic unit: sequencer, operand and result registers.
// Steps: cross products in S_MUL1 to S_MUL3, a binary gcd of the magnitudes
// (one shift or subtract per cycle), then two divisions by the gcd and the output register.
// Error and zero results skip the gcd and the divisions and go straight to S_FIN.
// One request at a time; a new one is taken while the previous result waits.
// Synchronous active-high reset returns to idle with no result pending.
`default_nettype none
module rational_arithmetic_unit #(
  parameter int WORD_WIDTH = 32
) (
  input wire logic  clk,
  input wire logic  rst,
  rau_req_if.sink   req,
  rau_rsp_if.source rsp
);
  localparam logic [63:0] LIM = (64'd1 << (WORD_WIDTH - 1)) - 64'd1;

  rau_pkg::state_t state, state_next;

  rau_pkg::action_t   act;
  logic signed [31:0] an, bn;
  logic [30:0]        ad, bd;
  logic signed [63:0] p1, p2, prod;
  logic signed [63:0] n_sum;
  logic               neg;
  logic [63:0]        nm, dm, nq;
  logic [63:0]        n_mag, d_mag;
  logic signed [32:0] op_a, op_b;
  logic signed [31:0] st_num;
  logic [30:0]        st_den;
  rau_pkg::status_t   st_status;

  logic        gcd_start, gcd_done, div_start, div_done;
  logic [63:0] gcd_g, div_q, div_dvd;
  logic        err_in, out_free;

  rau_mul u_mul (.clk(clk), .op_a(op_a), .op_b(op_b), .prod(prod));

  rau_gcd u_gcd (
    .clk(clk), .rst(rst), .start(gcd_start), .a(n_mag), .b(d_mag),
    .done(gcd_done), .g(gcd_g)
  );

  rau_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dvd),
    .divisor(gcd_g), .done(div_done), .quotient(div_q)
  );

  assign req.ready = (state == rau_pkg::S_IDLE);
  assign err_in = (req.a_den == 31'd0) || (req.b_den == 31'd0) ||
                  (rau_pkg::action_t'(req.action) == rau_pkg::ACT_DIV &&
                   req.b_num == 32'sd0);
  assign out_free = !rsp.valid || rsp.ready;

  // numerator: sum or difference of the two products for add and subtract, p1 alone otherwise
  always_comb begin
    case (act)
      rau_pkg::ACT_ADD: n_sum = p1 + p2;
      rau_pkg::ACT_SUB: n_sum = p1 - p2;
      default:          n_sum = p1;
    endcase
  end

  // magnitudes go straight to the gcd unit on its start cycle
  assign n_mag = n_sum[63] ? 64'd0 - n_sum : n_sum;
  assign d_mag = prod[63] ? 64'd0 - prod : prod;

  assign gcd_start = (state == rau_pkg::S_COMB) && (n_sum != 64'sd0);
  assign div_start = (state == rau_pkg::S_GCD && gcd_done) ||
                     (state == rau_pkg::S_DIVN && div_done);
  assign div_dvd   = (state == rau_pkg::S_GCD) ? nm : dm;

  // multiplier operands per step: numerator terms, then denominator
  always_comb begin
    op_a = 33'sd0;
    op_b = 33'sd0;
    case (state)
      rau_pkg::S_MUL1: begin
        op_a = {an[31], an};
        op_b = (act == rau_pkg::ACT_MUL) ? {bn[31], bn} : {2'b00, bd};
      end
      rau_pkg::S_MUL2: begin
        if (act == rau_pkg::ACT_ADD || act == rau_pkg::ACT_SUB) begin
          op_a = {bn[31], bn};
          op_b = {2'b00, ad};
        end
      end
      rau_pkg::S_MUL3: begin
        op_a = {2'b00, ad};
        op_b = (act == rau_pkg::ACT_DIV) ? {bn[31], bn} : {2'b00, bd};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rau_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rau_pkg::S_IDLE: if (req.valid) state_next = err_in ? rau_pkg::S_FIN : rau_pkg::S_MUL1;
      rau_pkg::S_MUL1: state_next = rau_pkg::S_MUL2;
      rau_pkg::S_MUL2: state_next = rau_pkg::S_MUL3;
      rau_pkg::S_MUL3: state_next = rau_pkg::S_COMB;
      rau_pkg::S_COMB: state_next = gcd_start ? rau_pkg::S_GCD : rau_pkg::S_FIN;
      rau_pkg::S_GCD:  if (gcd_done) state_next = rau_pkg::S_DIVN;
      rau_pkg::S_DIVN: if (div_done) state_next = rau_pkg::S_DIVD;
      rau_pkg::S_DIVD: if (div_done) state_next = rau_pkg::S_FIN;
      rau_pkg::S_FIN:  if (out_free) state_next = rau_pkg::S_IDLE;
      default:         state_next = rau_pkg::S_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      rau_pkg::S_IDLE: begin
        act <= rau_pkg::action_t'(req.action);
        an  <= req.a_num;
        ad  <= req.a_den;
        bn  <= req.b_num;
        bd  <= req.b_den;
        st_num    <= 32'sd0;
        st_den    <= 31'd0;
        st_status <= rau_pkg::ST_DIV_ZERO;
      end
      rau_pkg::S_MUL2: p1 <= prod;
      rau_pkg::S_MUL3: p2 <= prod;
      rau_pkg::S_COMB: begin
        neg <= n_sum[63] ^ prod[63];
        nm  <= n_mag;
        dm  <= d_mag;
        st_num    <= 32'sd0;
        st_den    <= 31'd1;
        st_status <= rau_pkg::ST_OK;
      end
      rau_pkg::S_DIVN: if (div_done) nq <= div_q;
      rau_pkg::S_DIVD: begin
        if (div_done) begin
          if (div_q > LIM || nq > LIM + {63'd0, neg}) begin
            st_num    <= 32'sd0;
            st_den    <= 31'd0;
            st_status <= rau_pkg::ST_OVERFLOW;
          end else begin
            st_num    <= neg ? 32'sd0 - nq[31:0] : nq[31:0];
            st_den    <= div_q[30:0];
            st_status <= rau_pkg::ST_OK;
          end
        end
      end
      default: ;
    endcase
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == rau_pkg::S_FIN && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rau_pkg::S_FIN && out_free) begin
      rsp.res_num <= st_num;
      rsp.res_den <= st_den;
      rsp.status  <= st_status;
    end
  end
endmodule
`default_nettype wire
